@@ src/lcd_bar_column_renderer_defines.svh @@
// Assertion helpers shared by the renderer modules.
`ifndef LCD_BAR_COLUMN_RENDERER_DEFINES_SVH
`define LCD_BAR_COLUMN_RENDERER_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define LCDBAR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lcdbar assertion failed");

// Next-cycle implication.
`define LCDBAR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lcdbar assertion failed");

`endif

@@ src/lcdbar_pkg.sv @@
package lcdbar_pkg;

  localparam int unsigned MaxBarPages = 8;
  localparam int unsigned QDepth      = 2;
  localparam int unsigned QPtrW       = $clog2(QDepth);

  localparam logic [6:0] WidthReset  = 7'd84;
  localparam logic [7:0] HeightReset = 8'd48;

  // register indexes
  localparam logic CfgWidth  = 1'b0;
  localparam logic CfgHeight = 1'b1;

  localparam logic ActSetCursor = 1'b0;
  localparam logic ActDraw      = 1'b1;

  localparam logic [7:0] CmdColumn = 8'h80;
  localparam logic [7:0] CmdLine   = 8'h40;
  localparam logic [7:0] ByteEmpty = 8'h00;
  localparam logic [7:0] ByteFull  = 8'hFF;

  typedef struct packed {
    logic [6:0] width;
    logic [7:0] height;
  } cfg_t;

  // one classified item, front to back
  typedef struct packed {
    logic       is_draw;
    logic [6:0] col0;   // wrapped start column
    logic [6:0] col1;   // wrapped column after the bar
    logic [4:0] line0;  // wrapped start line
    logic [3:0] lines;  // clamped page count, 1..MaxBarPages
    logic [2:0] mark;   // page holding the partial byte
    logic [3:0] shift;  // 0..8
  } entry_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_COL,
    B_LINE,
    B_DATA
  } back_state_e;

  // height/9 + 1, reciprocal multiply is exact for 8-bit heights
  function automatic logic [5:0] line_mod(logic [7:0] h);
    logic [13:0] p;
    p = 14'(h) * 14'd57;
    return 6'(p >> 9) + 6'd1;
  endfunction

  // zero width wraps at 128
  function automatic logic [7:0] col_mod(logic [6:0] w);
    return (w == 7'd0) ? 8'd128 : {1'b0, w};
  endfunction

endpackage

@@ src/lcdbar_rem.sv @@
// Restoring remainder, one dividend bit per cycle.
module lcdbar_rem (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [7:0] dividend_i,
  input  logic [7:0] divisor_i,
  output logic       busy_o,
  output logic [7:0] rem_o
);

  logic       busy_q, busy_d;
  logic [2:0] cnt_q, cnt_d;
  logic [7:0] dvd_q, dvd_d;
  logic [7:0] div_q, div_d;
  logic [7:0] rem_q, rem_d;
  logic [8:0] trial;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    div_d  = div_q;
    rem_d  = rem_q;
    trial  = {rem_q, dvd_q[7]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 3'd0;
      dvd_d  = dividend_i;
      div_d  = divisor_i;
      rem_d  = 8'd0;
    end else if (busy_q) begin
      if (trial >= {1'b0, div_q}) begin
        trial = trial - {1'b0, div_q};
      end
      rem_d = trial[7:0];
      dvd_d = {dvd_q[6:0], 1'b0};
      cnt_d = cnt_q + 3'd1;
      if (cnt_q == 3'd7) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 3'd0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q;

endmodule

@@ src/lcdbar_front.sv @@
// Accepts items, wraps cursor values, clamps the bar and tracks the cursor.
module lcdbar_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lcdbar_pkg::cfg_t      cfg_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  action_i,
  input  logic [7:0]            target_column_i,
  input  logic [7:0]            target_line_i,
  input  logic [3:0]            bar_lines_i,
  input  logic [7:0]            bar_value_i,
  output logic                  push_o,
  output lcdbar_pkg::entry_t    entry_o,
  input  logic                  full_i
);

  lcdbar_pkg::front_state_e state_q, state_d;

  logic [6:0] cur_col_q, cur_col_d;
  logic [4:0] cur_line_q, cur_line_d;
  logic       action_q;
  logic [3:0] lines_q;
  logic [7:0] value_q;

  logic       accept;
  logic       start;
  logic [7:0] col_div;
  logic [5:0] lmod;
  logic       col_busy, line_busy;
  logic [7:0] col_rem, line_rem;

  logic [7:0] col_inc;
  logic [3:0] lines_c;
  logic [6:0] total;
  logic [7:0] value_c;
  logic [6:0] diff;
  logic       full_bar;

  assign col_div = lcdbar_pkg::col_mod(cfg_i.width);
  assign lmod    = lcdbar_pkg::line_mod(cfg_i.height);
  assign accept  = in_valid_i && !in_stall_o;
  assign start   = accept;

  lcdbar_rem u_col_rem (
    .clk_i,
    .rst_ni,
    .start_i    (start),
    .dividend_i ((action_i == lcdbar_pkg::ActDraw) ? {1'b0, cur_col_q} : target_column_i),
    .divisor_i  (col_div),
    .busy_o     (col_busy),
    .rem_o      (col_rem)
  );

  lcdbar_rem u_line_rem (
    .clk_i,
    .rst_ni,
    .start_i    (start),
    .dividend_i ((action_i == lcdbar_pkg::ActDraw) ? {3'b000, cur_line_q} : target_line_i),
    .divisor_i  ({2'b00, lmod}),
    .busy_o     (line_busy),
    .rem_o      (line_rem)
  );

  // bar geometry
  always_comb begin
    if (lines_q == 4'd0) begin
      lines_c = 4'd1;
    end else if (lines_q > 4'(lcdbar_pkg::MaxBarPages)) begin
      lines_c = 4'(lcdbar_pkg::MaxBarPages);
    end else begin
      lines_c = lines_q;
    end
    total    = {lines_c, 3'b000};
    value_c  = (value_q > {1'b0, total}) ? {1'b0, total} : value_q;
    full_bar = (value_c == {1'b0, total});
    diff     = total - 7'd1 - value_c[6:0];
    col_inc  = {1'b0, col_rem[6:0]} + 8'd1;
  end

  always_comb begin
    entry_o.is_draw = (action_q == lcdbar_pkg::ActDraw);
    entry_o.col0    = col_rem[6:0];
    entry_o.col1    = (col_inc == col_div) ? 7'd0 : col_inc[6:0];
    entry_o.line0   = line_rem[4:0];
    entry_o.lines   = lines_c;
    entry_o.mark    = full_bar ? 3'd0 : diff[5:3];
    entry_o.shift   = full_bar ? 4'd0 : ({1'b0, diff[2:0]} + 4'd1);
  end

  always_comb begin
    state_d    = state_q;
    push_o     = 1'b0;
    cur_col_d  = cur_col_q;
    cur_line_d = cur_line_q;
    in_stall_o = (state_q != lcdbar_pkg::F_IDLE);
    unique case (state_q)
      lcdbar_pkg::F_IDLE: begin
        if (accept) begin
          state_d = lcdbar_pkg::F_DIV;
        end
      end
      lcdbar_pkg::F_DIV: begin
        if (!col_busy && !line_busy) begin
          state_d = lcdbar_pkg::F_PUSH;
        end
      end
      lcdbar_pkg::F_PUSH: begin
        if (!full_i) begin
          push_o     = 1'b1;
          cur_col_d  = entry_o.is_draw ? entry_o.col1 : entry_o.col0;
          cur_line_d = entry_o.line0;
          state_d    = lcdbar_pkg::F_IDLE;
        end
      end
      default: state_d = lcdbar_pkg::F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= lcdbar_pkg::F_IDLE;
      cur_col_q  <= 7'd0;
      cur_line_q <= 5'd0;
    end else begin
      state_q    <= state_d;
      cur_col_q  <= cur_col_d;
      cur_line_q <= cur_line_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      action_q <= action_i;
      lines_q  <= bar_lines_i;
      value_q  <= bar_value_i;
    end
  end

endmodule

@@ src/lcdbar_fifo.sv @@
`include "lcd_bar_column_renderer_defines.svh"

// Short queue of classified items between front and back.
module lcdbar_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  lcdbar_pkg::entry_t wdata_i,
  input  logic               pop_i,
  output lcdbar_pkg::entry_t rdata_o,
  output logic               full_o,
  output logic               empty_o
);

  localparam int unsigned PtrW = (lcdbar_pkg::QPtrW > 0) ? lcdbar_pkg::QPtrW : 1;

  lcdbar_pkg::entry_t mem_q [lcdbar_pkg::QDepth];

  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   count_q;

  function automatic logic [PtrW-1:0] ptr_next(logic [PtrW-1:0] p);
    return (p == PtrW'(lcdbar_pkg::QDepth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign full_o  = (count_q == (PtrW+1)'(lcdbar_pkg::QDepth));
  assign empty_o = (count_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + (PtrW+1)'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - (PtrW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  `LCDBAR_ASSERT_IMPL(a_no_push_full, push_i, count_q != (PtrW+1)'(lcdbar_pkg::QDepth))
  `LCDBAR_ASSERT_IMPL(a_no_pop_empty, pop_i, count_q != '0)

endmodule

@@ src/lcdbar_back.sv @@
`include "lcd_bar_column_renderer_defines.svh"

// Walks one classified item and emits its byte stream through an output register.
module lcdbar_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lcdbar_pkg::cfg_t   cfg_i,
  input  lcdbar_pkg::entry_t entry_i,
  input  logic               empty_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               is_data_o,
  output logic [7:0]         out_byte_o,
  output logic               last_o
);

  lcdbar_pkg::back_state_e state_q, state_d;
  lcdbar_pkg::entry_t      ent_q, ent_d;

  logic [2:0] page_q, page_d;
  logic [4:0] line_q, line_d;
  logic       final_q, final_d;

  logic       out_valid_q, out_valid_d;
  logic       out_data_q, out_data_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       out_last_q, out_last_d;

  logic       out_free;
  logic       emit;
  logic [5:0] lmod;
  logic [5:0] line_inc;
  logic [7:0] page_byte;

  assign lmod     = lcdbar_pkg::line_mod(cfg_i.height);
  assign out_free = !out_valid_q || !out_stall_i;
  assign line_inc = {1'b0, line_q} + 6'd1;

  always_comb begin
    if (page_q < ent_q.mark) begin
      page_byte = lcdbar_pkg::ByteEmpty;
    end else if (page_q == ent_q.mark) begin
      page_byte = lcdbar_pkg::ByteFull << ent_q.shift;
    end else begin
      page_byte = lcdbar_pkg::ByteFull;
    end
  end

  always_comb begin
    state_d    = state_q;
    ent_d      = ent_q;
    page_d     = page_q;
    line_d     = line_q;
    final_d    = final_q;
    pop_o      = 1'b0;
    emit       = 1'b0;
    out_data_d = out_data_q;
    out_byte_d = out_byte_q;
    out_last_d = out_last_q;
    unique case (state_q)
      lcdbar_pkg::B_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          ent_d   = entry_i;
          page_d  = 3'd0;
          line_d  = entry_i.line0;
          final_d = !entry_i.is_draw;
          state_d = lcdbar_pkg::B_COL;
        end
      end
      lcdbar_pkg::B_COL: begin
        if (out_free) begin
          emit       = 1'b1;
          out_data_d = 1'b0;
          out_byte_d = lcdbar_pkg::CmdColumn |
                       {1'b0, (ent_q.is_draw && final_q) ? ent_q.col1 : ent_q.col0};
          out_last_d = 1'b0;
          state_d    = lcdbar_pkg::B_LINE;
        end
      end
      lcdbar_pkg::B_LINE: begin
        if (out_free) begin
          emit       = 1'b1;
          out_data_d = 1'b0;
          out_byte_d = lcdbar_pkg::CmdLine | {3'b000, line_q};
          out_last_d = final_q;
          state_d    = final_q ? lcdbar_pkg::B_IDLE : lcdbar_pkg::B_DATA;
        end
      end
      lcdbar_pkg::B_DATA: begin
        if (out_free) begin
          emit       = 1'b1;
          out_data_d = 1'b1;
          out_byte_d = page_byte;
          out_last_d = 1'b0;
          state_d    = lcdbar_pkg::B_COL;
          if ({1'b0, page_q} == ent_q.lines - 4'd1) begin
            // cursor pair one column right on the start line
            final_d = 1'b1;
            line_d  = ent_q.line0;
          end else begin
            page_d = page_q + 3'd1;
            line_d = (line_inc == lmod) ? 5'd0 : line_inc[4:0];
          end
        end
      end
      default: state_d = lcdbar_pkg::B_IDLE;
    endcase
    out_valid_d = emit || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lcdbar_pkg::B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q      <= ent_d;
    page_q     <= page_d;
    line_q     <= line_d;
    final_q    <= final_d;
    out_data_q <= out_data_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign is_data_o   = out_data_q;
  assign out_byte_o  = out_byte_q;
  assign last_o      = out_last_q;

  `LCDBAR_ASSERT_IMPL(a_last_is_line_cmd, out_valid_q && out_last_q,
                      !out_data_q && (out_byte_q[7:6] == 2'b01))
  `LCDBAR_ASSERT_IMPL(a_pop_only_idle, pop_o,
                      (state_q == lcdbar_pkg::B_IDLE) && !empty_i)

endmodule

@@ src/lcd_bar_column_renderer.sv @@
// Channel | Direction | Handshake                  | Payload
// in      | input     | in_valid_i / in_stall_o    | action, target_column, target_line,
//         |           |                            | bar_lines, bar_value
// out     | output    | out_valid_o / out_stall_i  | is_data, out_byte, last
// cfg     | input     | cfg_we_i (no wait)         | cfg_idx_i, cfg_wdata_i
//
// Front: the accept edge starts two serial remainder units; once both are done and
// the queue has room, F_PUSH pushes, and no new item is taken before that push.
// Back: pops an item, then a byte per cycle unless the output stalls: 2 bytes for set
// cursor, 3*pages + 2 for a draw (5..26); the back paces draws of 3 pages or more.
// Reset: cursor at column 0 line 0, width 84, height 48, queue and output empty.
// A stalled output holds its byte; the back then waits, the two-entry queue
// fills and the front stalls its input.
module lcd_bar_column_renderer (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input transactions
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       action_i,
  input  logic [7:0] target_column_i,
  input  logic [7:0] target_line_i,
  input  logic [3:0] bar_lines_i,
  input  logic [7:0] bar_value_i,
  // output transactions
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       is_data_o,
  output logic [7:0] out_byte_o,
  output logic       last_o,
  // configuration writes
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [7:0] cfg_wdata_i
);

  lcdbar_pkg::cfg_t   cfg_q;
  lcdbar_pkg::entry_t push_entry, pop_entry;

  logic push, pop, full, empty;

  // config registers; the user must write them only while idle, the block does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width  <= lcdbar_pkg::WidthReset;
      cfg_q.height <= lcdbar_pkg::HeightReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lcdbar_pkg::CfgWidth:  cfg_q.width  <= cfg_wdata_i[6:0];
        lcdbar_pkg::CfgHeight: cfg_q.height <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // front: wraps coordinates, clamps the bar, keeps its own copy of the cursor
  lcdbar_front u_front (
    .clk_i,
    .rst_ni,
    .cfg_i           (cfg_q),
    .in_valid_i,
    .in_stall_o,
    .action_i,
    .target_column_i,
    .target_line_i,
    .bar_lines_i,
    .bar_value_i,
    .push_o          (push),
    .entry_o         (push_entry),
    .full_i          (full)
  );

  lcdbar_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .wdata_i (push_entry),
    .pop_i   (pop),
    .rdata_o (pop_entry),
    .full_o  (full),
    .empty_o (empty)
  );

  // back: byte sequencer, one output register
  lcdbar_back u_back (
    .clk_i,
    .rst_ni,
    .cfg_i       (cfg_q),
    .entry_i     (pop_entry),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o,
    .out_stall_i,
    .is_data_o,
    .out_byte_o,
    .last_o
  );

endmodule

@@ tb/sv/lcd_bar_column_renderer_tb.sv @@
`timescale 1ns / 100ps

// Self-checking bench for the bar column renderer: directed rows, then
// random phases under several width/height settings.
module lcd_bar_column_renderer_tb;
  import lcdbar_pkg::*;

  // No transaction on either channel for this long means a hang.
  localparam int unsigned IdleLimit      = 3000;
  // Cycles allowed after the last byte before the block counts as idle.
  localparam int unsigned SettleCycles   = 40;
  // One long receiver hold-off so the item queue fills and in_stall_o rises.
  localparam int unsigned LongHoldCycles = 400;
  localparam int          RandomPhases   = 6;
  localparam int          PhaseItems     = 65;

  typedef struct packed {
    logic       action;
    logic [7:0] tgt_col;
    logic [7:0] tgt_line;
    logic [3:0] pages;
    logic [7:0] value;
  } bar_item_t;

  typedef struct packed {
    logic       is_data;
    logic [7:0] data;
    logic       last;
  } lcd_byte_t;

  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_e;

  // Typed bytes are {is_data, byte}; last falls on the final one.
  typedef struct packed {
    row_kind_e       kind;
    bar_item_t       item;
    logic [2:0]      n_fixed;
    logic [4:0][8:0] fixed;
  } dir_row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic       action_i;
  logic [7:0] target_column_i;
  logic [7:0] target_line_i;
  logic [3:0] bar_lines_i;
  logic [7:0] bar_value_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic       is_data_o;
  logic [7:0] out_byte_o;
  logic       last_o;
  logic       cfg_we_i;
  logic       cfg_idx_i;
  logic [7:0] cfg_wdata_i;

  // Bench-side copy of the registers and the cursor.
  logic [6:0] width_q;
  logic [7:0] height_q;
  logic [6:0] cursor_col_q;
  logic [4:0] cursor_line_q;

  lcd_byte_t lcd_bytes_due[$];
  dir_row_t  dir_rows[$];

  int  errors         = 0;
  int  items_sent     = 0;
  int  bytes_seen     = 0;
  int  settings_used  = 0;
  bit  quiet_tail     = 1'b0;  // no idling on either side
  bit  hold_req       = 1'b0;  // one-shot long output hold-off

  lcd_bar_column_renderer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .action_i        (action_i),
    .target_column_i (target_column_i),
    .target_line_i   (target_line_i),
    .bar_lines_i     (bar_lines_i),
    .bar_value_i     (bar_value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .is_data_o       (is_data_o),
    .out_byte_o      (out_byte_o),
    .last_o          (last_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // ---------------------------------------------------------------------
  // Byte predictor
  // ---------------------------------------------------------------------

  // Width 0 wraps at 128.
  function automatic logic [6:0] wrap_col(logic [7:0] c);
    if (width_q == 7'd0) return c[6:0];
    return 7'(c % width_q);
  endfunction

  // Line modulus is height/9 + 1.
  function automatic logic [4:0] wrap_line(logic [7:0] l);
    int m;
    m = int'(height_q) / 9 + 1;
    return 5'(int'(l) % m);
  endfunction

  task automatic push_lcd_byte(logic is_data, logic [7:0] data);
    lcd_byte_t b;
    b.is_data = is_data;
    b.data    = data;
    b.last    = 1'b0;
    lcd_bytes_due.push_back(b);
  endtask

  // Wrap and store the cursor, then queue the column and line commands.
  task automatic place_cursor(logic [7:0] c, logic [7:0] l);
    cursor_col_q  = wrap_col(c);
    cursor_line_q = wrap_line(l);
    push_lcd_byte(1'b0, CmdColumn | {1'b0, cursor_col_q});
    push_lcd_byte(1'b0, CmdLine | {3'b000, cursor_line_q});
  endtask

  task automatic render_column_bytes(bar_item_t it);
    int         pages;
    int         total;
    int         val;
    int         mark;
    int         shift;
    int         p;
    logic [6:0] scol;
    logic [4:0] sline;
    logic [7:0] fill;
    if (it.action == ActSetCursor) begin
      place_cursor(it.tgt_col, it.tgt_line);
    end else begin
      scol  = cursor_col_q;
      sline = cursor_line_q;
      // page count clamps to 1..MaxBarPages
      pages = int'(it.pages);
      if (pages == 0) pages = 1;
      if (pages > int'(MaxBarPages)) pages = int'(MaxBarPages);
      total = pages * 8;
      val   = int'(it.value);
      if (val > total) val = total;
      // full bar puts the mark on the top page; shift 8 gives an empty byte
      mark  = (val == total) ? 0 : (total - 1 - val) / 8;
      shift = total - mark * 8 - val;
      for (p = 0; p < pages; p++) begin
        if (p < mark) fill = ByteEmpty;
        else if (p == mark) fill = ByteFull << shift;
        else fill = ByteFull;
        place_cursor({1'b0, scol}, 8'(sline) + 8'(p));
        push_lcd_byte(1'b1, fill);
      end
      place_cursor({1'b0, scol} + 8'd1, 8'(sline));
    end
    lcd_bytes_due[lcd_bytes_due.size() - 1].last = 1'b1;
  endtask

  // ---------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------

  // Holds the transaction until accepted. Acceptance is read at the falling
  // edge, where valid and stall are settled, and takes effect at the next
  // rising edge. Typed bytes replace the predicted ones but the cursor still
  // advances through the predictor.
  task automatic send_item(bar_item_t it, logic [2:0] n_fixed, logic [4:0][8:0] fixed);
    logic      taken;
    int        due_before;
    int        j;
    lcd_byte_t b;
    in_valid_i      <= 1'b1;
    action_i        <= it.action;
    target_column_i <= it.tgt_col;
    target_line_i   <= it.tgt_line;
    bar_lines_i     <= it.pages;
    bar_value_i     <= it.value;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = !in_stall_o;
      if (taken) begin
        due_before = lcd_bytes_due.size();
        render_column_bytes(it);
        if (n_fixed != 0) begin
          while (lcd_bytes_due.size() > due_before)
            lcd_bytes_due.delete(lcd_bytes_due.size() - 1);
          for (j = 0; j < int'(n_fixed); j++) begin
            b.is_data = fixed[j][8];
            b.data    = fixed[j][7:0];
            b.last    = (j == int'(n_fixed) - 1);
            lcd_bytes_due.push_back(b);
          end
        end
      end
      @(posedge clk_i);
    end
    items_sent++;
  endtask

  task automatic idle_in(int n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic sender_gap();
    if (!quiet_tail && $urandom_range(0, 3) == 0) idle_in($urandom_range(1, 19));
  endtask

  // Sender stops until every byte is back, then lets the pipe settle.
  task automatic wait_drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (lcd_bytes_due.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Block must be idle here. Enable is high for a single cycle, so back-to-back
  // calls never drive cfg_we_i twice in a step.
  task automatic write_reg(logic idx, logic [7:0] wdata);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= wdata;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == CfgWidth) width_q = wdata[6:0];
    else height_q = wdata;
  endtask

  task automatic apply_settings(logic [6:0] w, logic [7:0] h);
    write_reg(CfgWidth, {1'b0, w});
    write_reg(CfgHeight, h);
    settings_used++;
  endtask

  // Mostly draws, with some page counts outside 1..8 and values biased toward the
  // empty and full ends.
  function automatic bar_item_t random_bar_item();
    bar_item_t it;
    int        r;
    int        eff;
    it.action   = ($urandom_range(0, 9) < 3) ? ActSetCursor : ActDraw;
    it.tgt_col  = 8'($urandom_range(0, 255));
    it.tgt_line = 8'($urandom_range(0, 255));
    r = $urandom_range(0, 19);
    if (r == 0) it.pages = 4'd0;
    else if (r == 1) it.pages = 4'($urandom_range(9, 15));
    else it.pages = 4'($urandom_range(1, 8));
    eff = (it.pages == 4'd0) ? 1 : (it.pages > 4'd8) ? 8 : int'(it.pages);
    r = $urandom_range(0, 3);
    if (r == 0) it.value = 8'($urandom_range(0, 255));
    else if (r == 1) it.value = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'(eff * 8);
    else it.value = 8'($urandom_range(0, eff * 8));
    return it;
  endfunction

  task automatic add_row(row_kind_e kind, logic act, logic [7:0] col, logic [7:0] ln,
                         logic [3:0] pages, logic [7:0] value, int n = 0,
                         logic [8:0] b0 = '0, logic [8:0] b1 = '0, logic [8:0] b2 = '0,
                         logic [8:0] b3 = '0, logic [8:0] b4 = '0);
    dir_row_t row;
    row.kind          = kind;
    row.item.action   = act;
    row.item.tgt_col  = col;
    row.item.tgt_line = ln;
    row.item.pages    = pages;
    row.item.value    = value;
    row.n_fixed       = 3'(n);
    row.fixed         = {b4, b3, b2, b1, b0};
    dir_rows.push_back(row);
  endtask

  // ---------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------

  // Receiver pacing: random stall bursts, gap-free stretches, one long hold.
  initial begin : rx_pacing
    int busy_left;
    int free_left;
    busy_left   = 0;
    free_left   = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (busy_left > 0) busy_left--;
      if (busy_left == 0) begin
        if (hold_req) begin
          hold_req  = 1'b0;
          busy_left = LongHoldCycles;
        end else if (!quiet_tail) begin
          if (free_left > 0) free_left--;
          else if ($urandom_range(0, 19) == 0) free_left = $urandom_range(20, 80);
          else if ($urandom_range(0, 5) == 0) busy_left = $urandom_range(1, 19);
        end
      end
      out_stall_i <= (busy_left > 0);
    end
  end

  // Output transaction checker, sampled at the falling edge.
  always @(negedge clk_i) begin : byte_check
    lcd_byte_t exp_b;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (lcd_bytes_due.size() == 0) begin
        $error("unexpected byte: is_data=%0d out_byte=%02h last=%0d",
               is_data_o, out_byte_o, last_o);
        errors++;
      end else begin
        exp_b = lcd_bytes_due.pop_front();
        if (is_data_o !== exp_b.is_data) begin
          $error("is_data: expected %0d, got %0d", exp_b.is_data, is_data_o);
          errors++;
        end
        if (out_byte_o !== exp_b.data) begin
          $error("out_byte: expected %02h, got %02h", exp_b.data, out_byte_o);
          errors++;
        end
        if (last_o !== exp_b.last) begin
          $error("last: expected %0d, got %0d", exp_b.last, last_o);
          errors++;
        end
        bytes_seen++;
      end
    end
  end

  // Hang detector: cycles with no transaction on either channel.
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < IdleLimit) begin
      @(negedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("** lcd_bar_column_renderer: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  initial begin : stimulus
    logic [6:0] phase_w[RandomPhases];
    logic [7:0] phase_h[RandomPhases];
    int         ph;
    int         k;

    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    action_i        = ActSetCursor;
    target_column_i = '0;
    target_line_i   = '0;
    bar_lines_i     = '0;
    bar_value_i     = '0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CfgWidth;
    cfg_wdata_i     = '0;
    width_q         = WidthReset;
    height_q        = HeightReset;
    cursor_col_q    = '0;
    cursor_line_q   = '0;

    // Directed rows. Reset config: width 84, height 48 (line modulus 6).
    // Bit 8 of a typed byte is is_data.
    // right after reset: empty one-page bar at column 0 line 0
    add_row(ROW_ITEM, ActDraw, 8'd0, 8'd0, 4'd1, 8'd0, 5,
            9'h080, 9'h040, 9'h100, 9'h081, 9'h040);
    // full one-page bar
    add_row(ROW_ITEM, ActDraw, 8'd0, 8'd0, 4'd1, 8'd8, 5,
            9'h081, 9'h040, 9'h1FF, 9'h082, 9'h040);
    add_row(ROW_ITEM, ActSetCursor, 8'd0, 8'd0, 4'd0, 8'd0, 2, 9'h080, 9'h040);
    // top of both target fields; bar fields are ignored here
    add_row(ROW_ITEM, ActSetCursor, 8'd255, 8'd255, 4'd15, 8'd255, 2, 9'h083, 9'h043);
    // zero pages acts as one, value clamps to full
    add_row(ROW_ITEM, ActDraw, 8'd255, 8'd255, 4'd0, 8'd255, 5,
            9'h083, 9'h043, 9'h1FF, 9'h084, 9'h043);
    add_row(ROW_ITEM, ActDraw, 8'd0, 8'd0, 4'd15, 8'd0);   // pages clamp to 8, empty
    add_row(ROW_ITEM, ActDraw, 8'd0, 8'd0, 4'd8, 8'd64);   // exactly full
    add_row(ROW_ITEM, ActDraw, 8'd0, 8'd0, 4'd8, 8'd1);    // one pixel, bottom page
    add_row(ROW_ITEM, ActDraw, 8'd0, 8'd0, 4'd3, 8'd12);
    add_row(ROW_ITEM, ActSetCursor, 8'd83, 8'd5, 4'd0, 8'd0, 2, 9'h0D3, 9'h045);
    add_row(ROW_ITEM, ActDraw, 8'd0, 8'd0, 4'd2, 8'd7);    // line and column both wrap
    add_row(ROW_ITEM, ActSetCursor, 8'd84, 8'd6, 4'd0, 8'd0, 2, 9'h080, 9'h040);
    add_row(ROW_ITEM, ActSetCursor, 8'd100, 8'd7, 4'd15, 8'd255, 2, 9'h090, 9'h041);
    add_row(ROW_ITEM, ActDraw, 8'd0, 8'd0, 4'd9, 8'd40);
    add_row(ROW_ITEM, ActDraw, 8'd255, 8'd255, 4'd4, 8'd31);
    // zero width wraps at 128; height 255 gives line modulus 29
    add_row(ROW_CFG, ActDraw, 8'd0, 8'd255, 4'd0, 8'd0);
    add_row(ROW_ITEM, ActSetCursor, 8'd200, 8'd100, 4'd0, 8'd0, 2, 9'h0C8, 9'h04D);
    add_row(ROW_ITEM, ActDraw, 8'd0, 8'd0, 4'd8, 8'd33);
    add_row(ROW_ITEM, ActSetCursor, 8'd127, 8'd28, 4'd0, 8'd0, 2, 9'h0FF, 9'h05C);
    add_row(ROW_ITEM, ActDraw, 8'd0, 8'd0, 4'd1, 8'd3);    // column 127 + 1 wraps to 0
    // width 1 and height 8 (line modulus 1): everything lands on column 0 line 0
    add_row(ROW_CFG, ActDraw, 8'd1, 8'd8, 4'd0, 8'd0);
    add_row(ROW_ITEM, ActSetCursor, 8'd255, 8'd255, 4'd0, 8'd0, 2, 9'h080, 9'h040);
    add_row(ROW_ITEM, ActDraw, 8'd0, 8'd0, 4'd8, 8'd20);

    phase_w = '{7'd127, 7'd1, 7'd0, 7'd84, 7'($urandom_range(1, 127)),
                7'($urandom_range(1, 127))};
    phase_h = '{8'd255, 8'd8, 8'd200, 8'd48, 8'($urandom_range(8, 255)),
                8'($urandom_range(8, 255))};

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    settings_used = 1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        wait_drain();
        apply_settings(dir_rows[i].item.tgt_col[6:0], dir_rows[i].item.tgt_line);
      end else begin
        send_item(dir_rows[i].item, dir_rows[i].n_fixed, dir_rows[i].fixed);
        sender_gap();
      end
    end

    for (ph = 0; ph < RandomPhases; ph++) begin
      wait_drain();
      apply_settings(phase_w[ph], phase_h[ph]);
      if (ph == RandomPhases - 1) quiet_tail = 1'b1;
      if (ph == 1) begin
        // receiver holds off while items keep coming back to back
        hold_req = 1'b1;
        repeat (12) send_item(random_bar_item(), 3'd0, '0);
      end
      for (k = 0; k < PhaseItems; k++) begin
        send_item(random_bar_item(), 3'd0, '0);
        if (ph == 3 && k == PhaseItems / 2) wait_drain();
        else sender_gap();
      end
    end

    wait_drain();

    $display("Sent %0d input transactions, checked %0d output bytes over %0d settings.",
             items_sent, bytes_seen, settings_used);
    $display("Covered zero width, page clamping, empty/full bars and a long output hold-off.");
    if (errors == 0) begin
      $display("** lcd_bar_column_renderer: PASSED **");
    end else begin
      $display("** lcd_bar_column_renderer: FAILED **");
    end
    $finish;
  end

endmodule
